// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds at an edge -> post holds at the same edge
`define QLU_ASSERT_IMP(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("same-cycle implication failed");

// pre holds at an edge -> post holds at the next edge
`define QLU_ASSERT_NXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle implication failed");

`endif

// File: rtl/qlu_pkg.sv
// Shared constants and types of the Q-value update block.
`default_nettype none

package qlu_pkg;

	localparam int NUM_STATES  = 1024;
	localparam int NUM_ACTIONS = 4;

	localparam int STATE_W = $clog2(NUM_STATES);
	localparam int ACT_W   = $clog2(NUM_ACTIONS);
	localparam int REW_W   = 16;
	localparam int VAL_W   = 32;
	localparam int COEF_W  = 17;
	localparam int ROW_W   = NUM_ACTIONS * VAL_W;

	// stream payload widths, padded to whole bytes
	localparam int IN_BITS = 2 * STATE_W + ACT_W + REW_W;
	localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_W   = 2 * VAL_W;

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = CFG_IDX_W'(1);

	localparam logic [COEF_W-1:0] ONE_Q16   = COEF_W'(65536);
	localparam logic [COEF_W-1:0] ALPHA_RST = COEF_W'(32768);
	localparam logic [COEF_W-1:0] GAMMA_RST = COEF_W'(58982);

	// arithmetic widths
	localparam int PROD_W = COEF_W + 1 + VAL_W;   // gamma * max
	localparam int G_W    = VAL_W + 1;            // rounded gamma * max
	localparam int TGT_W  = VAL_W + 2;            // reward * 2^16 + g
	localparam int DIFF_W = TGT_W + 1;            // target - q
	localparam int DLO_W  = COEF_W;               // low slice of diff
	localparam int DHI_W  = DIFF_W - DLO_W;       // high slice of diff (signed)
	localparam int PL_W   = COEF_W + DLO_W;
	localparam int PH_W   = COEF_W + 1 + DHI_W;
	localparam int MIX_W  = 54;
	localparam int RND_W  = MIX_W - 16;

	typedef logic [NUM_ACTIONS-1:0][VAL_W-1:0] row_t;

	typedef struct packed {
		logic ld_best;   // following row on read data: latch its max
		logic ld_row;    // current row on read data: latch it, start gamma * max
		logic ld_diff;   // form target - q
		logic ld_part;   // alpha * diff partial products
	} qlu_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/tabular_q_value_update.sv
// Top level of the tabular Q-value update block: control, config, stream ports.
// Latency: from the accepting edge the sequencer runs ST_MAX, ST_MG, ST_TD, ST_ML and ST_WB;
// m_axis_tvalid rises on the edge that leaves ST_WB. A new item is taken only in ST_IDLE;
// row max, gamma product, alpha products and write-back run in turn over the
// single-read-port row memory. Reset: arst_n clears control and loads alpha = 0.5,
// gamma = 0.9; a clearing pass then zeros all 1024 rows with s_axis_tready held low.
`default_nettype none
`include "assert_macros.svh"

module tabular_q_value_update (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// config write channel
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic [qlu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [qlu_pkg::COEF_W-1:0]      cfg_data,
	// input stream
	input  wire logic                            s_axis_tvalid,
	output      logic                            s_axis_tready,
	// [9:0] cur_state, [11:10] taken_action, [27:12] reward_value,
	// [37:28] following_state, [39:38] zero
	input  wire logic [qlu_pkg::IN_W-1:0]        s_axis_tdata,
	// result stream
	output      logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// [31:0] new_value, [63:32] next_best_value
	output      logic [qlu_pkg::OUT_W-1:0]       m_axis_tdata
);

	// one-hot sequencer
	typedef enum logic [6:0] {
		ST_CLR  = 7'b0000001,   // zeroing sweep after reset
		ST_IDLE = 7'b0000010,   // take an item, read the following row
		ST_MAX  = 7'b0000100,   // following row arrives: max; read current row
		ST_MG   = 7'b0001000,   // current row arrives; gamma * max
		ST_TD   = 7'b0010000,   // target - q
		ST_ML   = 7'b0100000,   // alpha * (target - q)
		ST_WB   = 7'b1000000    // round, saturate, write back, present result
	} state_t;

	localparam int SW = qlu_pkg::STATE_W;
	localparam int AW = qlu_pkg::ACT_W;
	localparam int RW = qlu_pkg::REW_W;

	state_t                           state_q;
	logic [SW-1:0]                    clr_q;
	logic [SW-1:0]                    cur_q;
	logic [AW-1:0]                    act_q;
	logic signed [RW-1:0]             rew_q;
	logic [qlu_pkg::COEF_W-1:0]       alpha_q;
	logic [qlu_pkg::COEF_W-1:0]       gamma_q;
	logic                             out_valid_q;
	logic [qlu_pkg::OUT_W-1:0]        out_data_q;

	logic                             in_xact;
	logic                             cfg_xact;
	logic                             wb_go;
	logic [qlu_pkg::COEF_W-1:0]       cfg_clamped;

	logic                             mem_we;
	logic [SW-1:0]                    mem_waddr;
	qlu_pkg::row_t                    mem_wdata;
	logic                             mem_re;
	logic [SW-1:0]                    mem_raddr;
	qlu_pkg::row_t                    mem_rdata;

	qlu_pkg::qlu_ctrl_t               ctrl;
	logic signed [qlu_pkg::VAL_W-1:0] best;
	logic signed [qlu_pkg::VAL_W-1:0] new_value;
	qlu_pkg::row_t                    wr_row;

	// input fields
	logic [SW-1:0] in_cur;
	logic [AW-1:0] in_act;
	logic [RW-1:0] in_rew;
	logic [SW-1:0] in_next;

	assign in_cur  = s_axis_tdata[SW-1:0];
	assign in_act  = s_axis_tdata[SW+AW-1:SW];
	assign in_rew  = s_axis_tdata[SW+AW+RW-1:SW+AW];
	assign in_next = s_axis_tdata[2*SW+AW+RW-1:SW+AW+RW];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xact       = s_axis_tvalid && s_axis_tready;

	// result waits in the output register; only write-back holds for it
	assign wb_go = (state_q == ST_WB) && (!out_valid_q || m_axis_tready);

	// config: coefficients above 1.0 are stored as 1.0
	assign cfg_ready   = 1'b1;
	assign cfg_xact    = cfg_valid && cfg_ready;
	assign cfg_clamped = (cfg_data > qlu_pkg::ONE_Q16) ? qlu_pkg::ONE_Q16 : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= qlu_pkg::ALPHA_RST;
			gamma_q <= qlu_pkg::GAMMA_RST;
		end else if (cfg_xact) begin
			case (cfg_index)
				qlu_pkg::CFG_LEARN_RATE: alpha_q <= cfg_clamped;
				qlu_pkg::CFG_DISCOUNT:   gamma_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(qlu_pkg::NUM_STATES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xact) begin
						state_q <= ST_MAX;
					end
				end
				ST_MAX: state_q <= ST_MG;
				ST_MG:  state_q <= ST_TD;
				ST_TD:  state_q <= ST_ML;
				ST_ML:  state_q <= ST_WB;
				ST_WB: begin
					if (wb_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item fields held for the whole update
	always_ff @(posedge clk) begin
		if (in_xact) begin
			cur_q <= in_cur;
			act_q <= in_act;
			rew_q <= $signed(in_rew);
		end
	end

	// memory ports: following row is read on the accepting edge, current row next
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = cur_q;
		if (state_q == ST_IDLE) begin
			mem_re    = in_xact;
			mem_raddr = in_next;
		end else if (state_q == ST_MAX) begin
			mem_re    = 1'b1;
			mem_raddr = cur_q;
		end
	end

	always_comb begin
		if (state_q == ST_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = wb_go;
			mem_waddr = cur_q;
			mem_wdata = wr_row;
		end
	end

	assign ctrl.ld_best = (state_q == ST_MAX);
	assign ctrl.ld_row  = (state_q == ST_MG);
	assign ctrl.ld_diff = (state_q == ST_TD);
	assign ctrl.ld_part = (state_q == ST_ML);

	qlu_row_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	qlu_dpath u_dpath (
		.clk       (clk),
		.ctrl      (ctrl),
		.rdata     (mem_rdata),
		.action    (act_q),
		.reward    (rew_q),
		.alpha     (alpha_q),
		.gamma     (gamma_q),
		.best      (best),
		.new_value (new_value),
		.wr_row    (wr_row)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			out_data_q <= {best, new_value};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// checks
	`QLU_ASSERT_NXT(a_wb_shows_result, clk, arst_n, wb_go, m_axis_tvalid)
	`QLU_ASSERT_IMP(a_write_only_wb_or_clr, clk, arst_n, mem_we,
		(state_q == ST_WB) || (state_q == ST_CLR))
	`QLU_ASSERT_NXT(a_clear_ends_at_last_row, clk, arst_n,
		(state_q == ST_CLR) && (clr_q == SW'(qlu_pkg::NUM_STATES - 1)), state_q == ST_IDLE)
	`QLU_ASSERT_NXT(a_clear_runs_once, clk, arst_n, state_q != ST_CLR, state_q != ST_CLR)

endmodule

`default_nettype wire

// File: rtl/qlu_row_ram.sv
// Value table: one row of all action values per state, registered read.
`default_nettype none

module qlu_row_ram (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [qlu_pkg::STATE_W-1:0] waddr,
	input  wire qlu_pkg::row_t               wdata,
	input  wire logic                        re,
	input  wire logic [qlu_pkg::STATE_W-1:0] raddr,
	output      qlu_pkg::row_t               rdata
);

	qlu_pkg::row_t mem [qlu_pkg::NUM_STATES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/qlu_dpath.sv
// Update arithmetic: row max, gamma and alpha products, rounding, saturation.
`default_nettype none

module qlu_dpath (
	input  wire logic                             clk,
	input  wire qlu_pkg::qlu_ctrl_t               ctrl,
	input  wire qlu_pkg::row_t                    rdata,
	input  wire logic [qlu_pkg::ACT_W-1:0]        action,
	input  wire logic signed [qlu_pkg::REW_W-1:0] reward,
	input  wire logic [qlu_pkg::COEF_W-1:0]       alpha,
	input  wire logic [qlu_pkg::COEF_W-1:0]       gamma,
	output      logic signed [qlu_pkg::VAL_W-1:0] best,
	output      logic signed [qlu_pkg::VAL_W-1:0] new_value,
	output      qlu_pkg::row_t                    wr_row
);

	logic signed [qlu_pkg::VAL_W-1:0]  best_q;
	logic signed [qlu_pkg::VAL_W-1:0]  row_max;
	qlu_pkg::row_t                     row_q;
	logic signed [qlu_pkg::PROD_W-1:0] prod_q;
	logic signed [qlu_pkg::DIFF_W-1:0] diff_q;
	logic        [qlu_pkg::PL_W-1:0]   pl_q;
	logic signed [qlu_pkg::PH_W-1:0]   ph_q;

	logic signed [qlu_pkg::VAL_W-1:0]  q_old;
	logic signed [qlu_pkg::PROD_W-1:0] g_sum;
	logic signed [qlu_pkg::G_W-1:0]    g_val;
	logic signed [qlu_pkg::TGT_W-1:0]  target;
	logic signed [qlu_pkg::DIFF_W-1:0] diff_d;
	logic signed [qlu_pkg::MIX_W-1:0]  mix;
	logic signed [qlu_pkg::RND_W-1:0]  rnd;
	logic        [qlu_pkg::DLO_W-1:0]  d_lo;
	logic signed [qlu_pkg::DHI_W-1:0]  d_hi;

	// max over the following state's row
	always_comb begin
		row_max = $signed(rdata[0]);
		for (int i = 1; i < qlu_pkg::NUM_ACTIONS; i++) begin
			if ($signed(rdata[i]) > row_max) begin
				row_max = $signed(rdata[i]);
			end
		end
	end

	assign q_old = $signed(row_q[action]);

	// g = floor((gamma * max + 2^15) / 2^16); t = reward * 2^16 + g
	assign g_sum  = prod_q + qlu_pkg::PROD_W'(32768);
	assign g_val  = g_sum[qlu_pkg::G_W+15:16];
	assign target = qlu_pkg::TGT_W'($signed({reward, 16'h0000})) + qlu_pkg::TGT_W'(g_val);
	assign diff_d = qlu_pkg::DIFF_W'(target) - qlu_pkg::DIFF_W'(q_old);

	assign d_lo = diff_q[qlu_pkg::DLO_W-1:0];
	assign d_hi = diff_q[qlu_pkg::DIFF_W-1:qlu_pkg::DLO_W];

	always_ff @(posedge clk) begin
		if (ctrl.ld_best) begin
			best_q <= row_max;
		end
		if (ctrl.ld_row) begin
			row_q  <= rdata;
			prod_q <= qlu_pkg::PROD_W'($signed({1'b0, gamma}) * best_q);
		end
		if (ctrl.ld_diff) begin
			diff_q <= diff_d;
		end
		if (ctrl.ld_part) begin
			pl_q <= qlu_pkg::PL_W'(alpha) * qlu_pkg::PL_W'(d_lo);
			ph_q <= qlu_pkg::PH_W'($signed({1'b0, alpha}) * d_hi);
		end
	end

	// (1 - a) * q + a * t  ==  q * 2^16 + a * (t - q), plus half for rounding
	assign mix = $signed({q_old, 16'h0000})
		+ $signed({ph_q, {qlu_pkg::DLO_W{1'b0}}})
		+ $signed({1'b0, pl_q})
		+ qlu_pkg::MIX_W'(32768);
	assign rnd = mix[qlu_pkg::MIX_W-1:16];

	always_comb begin
		if (rnd[qlu_pkg::RND_W-1:qlu_pkg::VAL_W-1] == '0
				|| rnd[qlu_pkg::RND_W-1:qlu_pkg::VAL_W-1] == '1) begin
			new_value = rnd[qlu_pkg::VAL_W-1:0];
		end else if (rnd[qlu_pkg::RND_W-1]) begin
			new_value = {1'b1, {(qlu_pkg::VAL_W-1){1'b0}}};
		end else begin
			new_value = {1'b0, {(qlu_pkg::VAL_W-1){1'b1}}};
		end
	end

	always_comb begin
		wr_row = row_q;
		wr_row[action] = new_value;
	end

	assign best = best_q;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the tabular Q-value update block: table predictor and stream checks.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// register index that maps to no register; writes to it must change nothing
	localparam logic [qlu_pkg::CFG_IDX_W-1:0] CFG_NO_REG = qlu_pkg::CFG_IDX_W'(8'hFF);
	// cycles allowed after the last result before a register write or the end:
	// the table write-back lands with the result register
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT   = 50000;
	localparam int HOLD_CYCLES   = 400;
	localparam int MAX_REPORTS   = 10;

	// input transaction, first field in the lowest bits
	typedef struct packed {
		logic [qlu_pkg::IN_W-qlu_pkg::IN_BITS-1:0] pad;
		logic [qlu_pkg::STATE_W-1:0]               following_state;
		logic signed [qlu_pkg::REW_W-1:0]          reward_value;
		logic [qlu_pkg::ACT_W-1:0]                 taken_action;
		logic [qlu_pkg::STATE_W-1:0]               cur_state;
	} update_req_t;

	// result transaction: new_value in the low word
	typedef struct packed {
		logic signed [qlu_pkg::VAL_W-1:0] next_best_value;
		logic signed [qlu_pkg::VAL_W-1:0] new_value;
	} update_res_t;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// Mirror of the action-value table plus the queue of results still owed.
	class qvalue_tracker;
		int          value_table [qlu_pkg::NUM_STATES * qlu_pkg::NUM_ACTIONS];
		logic [qlu_pkg::COEF_W-1:0] learn_rate;
		logic [qlu_pkg::COEF_W-1:0] discount;
		update_res_t owed_updates [$];
		int          mismatches;
		int          checked;

		function new();
			learn_rate = qlu_pkg::ALPHA_RST;
			discount   = qlu_pkg::GAMMA_RST;
			foreach (value_table[i])
				value_table[i] = 0;
			mismatches = 0;
			checked    = 0;
		endfunction

		function void note_config(logic [qlu_pkg::CFG_IDX_W-1:0] idx,
				logic [qlu_pkg::COEF_W-1:0] data);
			if (idx == qlu_pkg::CFG_LEARN_RATE)
				learn_rate = data;
			else if (idx == qlu_pkg::CFG_DISCOUNT)
				discount = data;
		endfunction

		// Q' = (1 - alpha) * Q + alpha * (reward + gamma * max), both roundings half up
		function void note_update(update_req_t req);
			int unsigned row;
			int unsigned next_row;
			int unsigned slot;
			int          best;
			longint      alpha;
			longint      gamma;
			longint      q_old;
			longint      scaled_best;
			longint      target;
			longint      mix;
			longint      rounded;
			update_res_t res;
			row      = int'(req.cur_state) % qlu_pkg::NUM_STATES;
			next_row = int'(req.following_state) % qlu_pkg::NUM_STATES;
			slot     = row * qlu_pkg::NUM_ACTIONS
				+ int'(req.taken_action) % qlu_pkg::NUM_ACTIONS;
			alpha    = (learn_rate > qlu_pkg::ONE_Q16) ? longint'(qlu_pkg::ONE_Q16)
				: longint'(learn_rate);
			gamma    = (discount > qlu_pkg::ONE_Q16) ? longint'(qlu_pkg::ONE_Q16)
				: longint'(discount);
			// row max taken before this transaction's write, also when rows match
			best = value_table[next_row * qlu_pkg::NUM_ACTIONS];
			for (int i = 1; i < qlu_pkg::NUM_ACTIONS; i++)
				if (value_table[next_row * qlu_pkg::NUM_ACTIONS + i] > best)
					best = value_table[next_row * qlu_pkg::NUM_ACTIONS + i];
			q_old       = longint'(value_table[slot]);
			scaled_best = (gamma * longint'(best) + 32768) >>> 16;
			target      = longint'(req.reward_value) * 65536 + scaled_best;
			mix         = (longint'(qlu_pkg::ONE_Q16) - alpha) * q_old + alpha * target;
			rounded     = (mix + 32768) >>> 16;
			if (rounded > 64'sd2147483647)
				res.new_value = 32'sh7FFF_FFFF;
			else if (rounded < -64'sd2147483648)
				res.new_value = 32'sh8000_0000;
			else
				res.new_value = qlu_pkg::VAL_W'(rounded);
			res.next_best_value = best;
			value_table[slot]   = res.new_value;
			owed_updates = {owed_updates, res};
		endfunction

		function void check_update(logic [qlu_pkg::OUT_W-1:0] raw);
			update_res_t got;
			update_res_t want;
			got = raw;
			checked++;
			if (owed_updates.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result new_value=%0d next_best=%0d",
						$realtime, got.new_value, got.next_best_value);
				return;
			end
			want = owed_updates.pop_front();
			if (got.new_value !== want.new_value ||
				got.next_best_value !== want.next_best_value) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result %0d: new_value exp %0d got %0d, %s %0d got %0d",
						$realtime, checked, want.new_value, got.new_value,
						"next_best exp", want.next_best_value, got.next_best_value);
			end
		endfunction

		function void check_leftover();
			if (owed_updates.size() != 0) begin
				mismatches++;
				$display("%0d results never arrived", owed_updates.size());
			end
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [qlu_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [qlu_pkg::COEF_W-1:0]        cfg_data;
	logic                              s_axis_tvalid;
	logic                              s_axis_tready;
	logic [qlu_pkg::IN_W-1:0]          s_axis_tdata;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready;
	logic [qlu_pkg::OUT_W-1:0]         m_axis_tdata;

	qvalue_tracker tracker = new();
	idle_mode_t    idle_mode = IDLE_NONE;
	int            hold_off_left = 0;
	int            items_sent = 0;
	int            settings_applied = 0;
	logic [qlu_pkg::STATE_W-1:0] last_row = '0;

	tabular_q_value_update dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop; far beyond the slowest legal run including the clearing pass
	initial begin
		#4ms;
		$display("[tabular_q_value_update] ERROR");
		$finish;
	end

	// Result side: random stalls per idle mode, plus one long hold-off on request.
	// The hold-off is counted here so the sender keeps pushing meanwhile.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_off_left--;
			end else begin
				case (idle_mode)
					IDLE_RECEIVER: m_axis_tready <= ($urandom_range(99) >= 76);
					IDLE_BOTH:     m_axis_tready <= ($urandom_range(99) >= 30);
					default:       m_axis_tready <= 1'b1;
				endcase
			end
		end
	end

	// Sample outputs at the edge: values seen here are the pre-edge ones.
	always @(posedge clk)
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
			tracker.check_update(m_axis_tdata);

	function automatic int sender_idle_pct();
		case (idle_mode)
			IDLE_SENDER: return 76;
			IDLE_BOTH:   return 30;
			default:     return 0;
		endcase
	endfunction

	// Offer one transaction; valid stays high afterwards so back-to-back items need
	// no second assignment in the same step. Caller lowers it when the burst ends.
	task automatic send_item(update_req_t req);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct())
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= req;
		do
			@(posedge clk);
		while (s_axis_tready !== 1'b1);
		tracker.note_update(req);
		items_sent++;
	endtask

	task automatic send_fields(int cur, int act, int rew, int nxt);
		update_req_t req;
		req = '0;
		req.cur_state       = qlu_pkg::STATE_W'(cur);
		req.taken_action    = qlu_pkg::ACT_W'(act);
		req.reward_value    = qlu_pkg::REW_W'(rew);
		req.following_state = qlu_pkg::STATE_W'(nxt);
		send_item(req);
	endtask

	task automatic write_reg(logic [qlu_pkg::CFG_IDX_W-1:0] idx,
			logic [qlu_pkg::COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		tracker.note_config(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait out every owed result (bounded), then let the write-back settle.
	task automatic wait_all_results();
		int waited;
		waited = 0;
		while (tracker.owed_updates.size() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Registers only change with the block idle.
	task automatic reconfigure(logic [qlu_pkg::COEF_W-1:0] alpha,
			logic [qlu_pkg::COEF_W-1:0] gamma);
		s_axis_tvalid <= 1'b0;
		wait_all_results();
		write_reg(qlu_pkg::CFG_LEARN_RATE, alpha);
		write_reg(qlu_pkg::CFG_DISCOUNT, gamma);
		// stray index with random data; must be ignored
		write_reg(qlu_pkg::CFG_IDX_W'($urandom_range(255, 2)), qlu_pkg::COEF_W'($urandom));
		settings_applied++;
	endtask

	function automatic logic [qlu_pkg::STATE_W-1:0] pool_row();
		if ($urandom_range(7) == 0)
			return qlu_pkg::STATE_W'(qlu_pkg::NUM_STATES - 1 - $urandom_range(3));
		return qlu_pkg::STATE_W'($urandom_range(15));
	endfunction

	// Mostly a small set of rows so values build up and rows get reused back to
	// back (read-after-write hazard); the rest spans the whole index range.
	function automatic update_req_t random_item();
		update_req_t req;
		int unsigned pick;
		req  = '0;
		pick = $urandom_range(99);
		if (pick < 70) begin
			req.cur_state       = pool_row();
			req.following_state = ($urandom_range(3) == 0) ? last_row : pool_row();
		end else if (pick < 92) begin
			req.cur_state       = qlu_pkg::STATE_W'($urandom);
			req.following_state = qlu_pkg::STATE_W'($urandom);
		end else begin
			req.cur_state       = last_row;
			req.following_state = last_row;
		end
		req.taken_action = qlu_pkg::ACT_W'($urandom);
		case ($urandom_range(9))
			0:          req.reward_value = 16'sh7FFF;
			1:          req.reward_value = 16'sh8000;
			2, 3, 4, 5: req.reward_value = qlu_pkg::REW_W'(int'($urandom_range(40)) - 20);
			default:    req.reward_value = qlu_pkg::REW_W'($urandom);
		endcase
		last_row = req.cur_state;
		return req;
	endfunction

	task automatic run_random(int count, idle_mode_t mode);
		idle_mode = mode;
		repeat (count)
			send_item(random_item());
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients (0.5, 0.9): field extremes, same row, row 0 reuse
		send_fields(0, 0, 32767, qlu_pkg::NUM_STATES - 1);
		send_fields(qlu_pkg::NUM_STATES - 1, 3, -32768, 0);
		send_fields(0, 1, 1, 0);
		send_fields(0, 2, -1, 0);
		send_fields(qlu_pkg::NUM_STATES - 1, 2, 100, qlu_pkg::NUM_STATES - 1);
		send_fields(512, 1, -5, 0);
		send_fields(0, 3, 0, 0);
		run_random(60, IDLE_NONE);
		// long output hold-off while input keeps coming: block must back-pressure
		hold_off_left = HOLD_CYCLES;
		run_random(240, IDLE_NONE);

		// alpha = gamma = 1.0: drive values to both saturation rails
		reconfigure(qlu_pkg::ONE_Q16, qlu_pkg::ONE_Q16);
		repeat (3) send_fields(7, 0, 32767, 7);
		for (int a = 0; a < qlu_pkg::NUM_ACTIONS; a++)
			send_fields(9, a, -32768, 9);
		send_fields(9, 0, -32768, 9);
		run_random(300, IDLE_SENDER);

		// learning off, zero discount: table entries must not move
		reconfigure('0, '0);
		send_fields(0, 0, 32767, qlu_pkg::NUM_STATES - 1);
		send_fields(9, 1, -32768, 0);
		run_random(150, IDLE_RECEIVER);

		// coefficients above one clamp to 1.0; stray index write of all ones
		reconfigure('1, '1);
		write_reg(CFG_NO_REG, '0);
		send_fields(7, 1, -32768, 9);
		run_random(200, IDLE_BOTH);

		// random settings, mostly within range, one small alpha
		reconfigure(qlu_pkg::COEF_W'(1), qlu_pkg::COEF_W'($urandom_range(65536)));
		run_random(240, IDLE_NONE);
		for (int p = 0; p < 3; p++) begin
			reconfigure(
				qlu_pkg::COEF_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(65536)),
				qlu_pkg::COEF_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(65536)));
			run_random(240, idle_mode_t'(p + 1));
		end

		s_axis_tvalid <= 1'b0;
		wait_all_results();
		tracker.check_leftover();

		$display("covered %0d updates over %0d coefficient settings, %0d results checked",
			items_sent, settings_applied + 1, tracker.checked);
		$display("incl. saturation, clamped coefficients, learning off and output back-pressure");
		if (tracker.mismatches == 0) begin
			$display("[tabular_q_value_update] OK");
		end else begin
			$display("%0d mismatches", tracker.mismatches);
			$display("[tabular_q_value_update] ERROR");
		end
		$finish;
	end

endmodule
